// ----- rtl/lpmf_pkg.sv -----
// ----------------------------------------------------------------------------
// lpmf_pkg
// Shared types and constants of the length-prefixed message FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package lpmf_pkg;

  // Ring geometry (power of two); pointers carry one wrap bit
  localparam int DEPTH     = 4096;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int PTR_W     = ADDR_W + 1;
  localparam int HDR_BYTES = 4;

  // Field widths
  localparam int LEN_W      = 16;
  localparam int BYTE_W     = 8;
  localparam int COUNT_W    = 13;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;
  localparam int CMP_W      = (PTR_W > LEN_W) ? PTR_W : LEN_W;

  typedef enum logic [1:0] {
    ACT_START   = 2'd0,
    ACT_PAYLOAD = 2'd1,
    ACT_READ    = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_ROOM  = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_ZERO_LEN = 3'd3,
    ST_DROPPED  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_START,
    S_HDR,
    S_RHDR1,
    S_RHDR2,
    S_DONE
  } state_t;

  // Request to the byte store
  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] wdata;
  } mem_req_t;

  // One result item
  typedef struct packed {
    status_t            status;
    logic [BYTE_W-1:0]  read_data;
    logic               last;
    logic [COUNT_W-1:0] used;
    logic [COUNT_W-1:0] free;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/length_prefixed_message_fifo_core.sv -----
// ----------------------------------------------------------------------------
// length_prefixed_message_fifo_core
// Byte ring of length-prefixed messages held in a single-port RAM.
// ----------------------------------------------------------------------------
// Payload byte, clear, in-message read and empty read each make at most one RAM access;
//   a read that takes a header first reads two header bytes through the RAM port.
// Start message writes four header bytes, none when refused, after padding with zero bytes
//   an unfinished message. The RAM port makes one access per cycle; a new item is taken
//   only once the last result has passed to the output register.
// The output register frees the sequencer while a result waits; sync reset empties the ring.
`default_nettype none

module length_prefixed_message_fifo_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Input items
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [lpmf_pkg::IN_DATA_W-1:0]    s_tdata,  // msg_length, write_data
  input  wire logic [1:0]                        s_tuser,  // action
  // Result items
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic      [lpmf_pkg::OUT_DATA_W-1:0]   m_tdata,  // read_data, used_bytes, free_bytes
  output logic      [2:0]                        m_tuser,  // status
  output logic                                   m_tlast   // last_byte
);

  lpmf_pkg::mem_req_t mem_req;
  logic [lpmf_pkg::BYTE_W-1:0] mem_rdata;
  lpmf_pkg::result_t  res;
  lpmf_pkg::result_t  res_q;
  logic               res_valid;
  logic               res_ready;

  lpmf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_action (lpmf_pkg::action_t'(s_tuser)),
    .in_length (s_tdata[15:0]),
    .in_data   (s_tdata[23:16]),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  lpmf_ram #(
    .ADDR_W (lpmf_pkg::ADDR_W),
    .DATA_W (lpmf_pkg::BYTE_W)
  ) u_ram (
    .clk   (clk),
    .en    (mem_req.en),
    .we    (mem_req.we),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (mem_rdata)
  );

  // Output register: load when empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      res_q <= res;
    end
  end

  // Pack the result
  assign m_tdata = lpmf_pkg::OUT_DATA_W'({res_q.free, res_q.used, res_q.read_data});
  assign m_tuser = res_q.status;
  assign m_tlast = res_q.last;

endmodule

`default_nettype wire

// ----- rtl/lpmf_ram.sv -----
// ----------------------------------------------------------------------------
// lpmf_ram
// Single-port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lpmf_ram #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [DATA_W-1:0] wdata,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // Write or read; read data holds until the next read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lpmf_ctrl.sv -----
// ----------------------------------------------------------------------------
// lpmf_ctrl
// Sequencer of the message ring: pointers, remaining counts, header framing
// and the access schedule of the byte store.
// ----------------------------------------------------------------------------
`default_nettype none

module lpmf_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Item input
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire lpmf_pkg::action_t             in_action,
  input  wire logic [lpmf_pkg::LEN_W-1:0]    in_length,
  input  wire logic [lpmf_pkg::BYTE_W-1:0]   in_data,
  // Byte store
  output lpmf_pkg::mem_req_t                 mem_req,
  input  wire logic [lpmf_pkg::BYTE_W-1:0]   mem_rdata,
  // Result
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output lpmf_pkg::result_t                  res
);

  localparam int PW = lpmf_pkg::PTR_W;
  localparam int LW = lpmf_pkg::LEN_W;
  localparam int CW = lpmf_pkg::CMP_W;

  lpmf_pkg::state_t  state, state_next;
  logic [PW-1:0]     wp, wp_next;
  logic [PW-1:0]     rp, rp_next;
  logic [LW-1:0]     wr_rem, wr_rem_next;
  logic [LW-1:0]     rd_rem, rd_rem_next;
  logic              in_msg, in_msg_next;
  logic [LW-1:0]     req_len, req_len_next;
  logic [LW-1:0]     count, count_next;
  logic [1:0]        hdr_idx, hdr_idx_next;
  logic [7:0]        len_lo, len_lo_next;
  lpmf_pkg::status_t res_status, res_status_next;
  logic              res_last, res_last_next;
  logic              res_use_q, res_use_q_next;

  logic [PW-1:0]     used;
  logic [PW-1:0]     room;
  logic [PW-1:0]     avail;
  logic [CW-1:0]     req_x;
  logic [CW-1:0]     avail_x;
  logic [LW-1:0]     count_new;
  logic [7:0]        hdr_byte;
  logic [LW-1:0]     hdr_len;
  logic [PW-1:0]     rp_body;
  logic              accept;

  // Occupancy and room
  assign used    = wp - rp;
  assign room    = PW'(lpmf_pkg::DEPTH) - used;
  assign avail   = room - PW'(lpmf_pkg::HDR_BYTES);
  assign req_x   = CW'(req_len);
  assign avail_x = CW'(avail);
  assign count_new = (req_x > avail_x) ? LW'(avail_x) : LW'(req_x);
  assign hdr_len = {mem_rdata, len_lo};
  assign rp_body = rp + PW'(2);
  assign in_ready = (state == lpmf_pkg::S_IDLE);
  assign accept  = in_valid && in_ready;

  // Header byte, little endian; upper bytes are always zero
  always_comb begin
    unique case (hdr_idx)
      2'd0: hdr_byte = count[7:0];
      2'd1: hdr_byte = count[15:8];
      2'd2: hdr_byte = 8'h00;
      2'd3: hdr_byte = 8'h00;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      lpmf_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_action)
            lpmf_pkg::ACT_START: begin
              state_next = (wr_rem != '0) ? lpmf_pkg::S_FILL : lpmf_pkg::S_START;
            end
            lpmf_pkg::ACT_READ: begin
              if (!in_msg && used >= PW'(lpmf_pkg::HDR_BYTES)) begin
                state_next = lpmf_pkg::S_RHDR1;
              end else begin
                state_next = lpmf_pkg::S_DONE;
              end
            end
            lpmf_pkg::ACT_PAYLOAD: state_next = lpmf_pkg::S_DONE;
            lpmf_pkg::ACT_CLEAR:   state_next = lpmf_pkg::S_DONE;
          endcase
        end
      end
      lpmf_pkg::S_FILL: begin
        if (wr_rem == LW'(1)) begin
          state_next = lpmf_pkg::S_START;
        end
      end
      lpmf_pkg::S_START: begin
        state_next = (room <= PW'(lpmf_pkg::HDR_BYTES)) ? lpmf_pkg::S_DONE : lpmf_pkg::S_HDR;
      end
      lpmf_pkg::S_HDR: begin
        if (hdr_idx == 2'd3) begin
          state_next = lpmf_pkg::S_DONE;
        end
      end
      lpmf_pkg::S_RHDR1: state_next = lpmf_pkg::S_RHDR2;
      lpmf_pkg::S_RHDR2: state_next = lpmf_pkg::S_DONE;
      lpmf_pkg::S_DONE: begin
        if (res_ready) begin
          state_next = lpmf_pkg::S_IDLE;
        end
      end
      default: state_next = lpmf_pkg::S_IDLE;
    endcase
  end

  // Datapath updates and store accesses
  always_comb begin
    wp_next         = wp;
    rp_next         = rp;
    wr_rem_next     = wr_rem;
    rd_rem_next     = rd_rem;
    in_msg_next     = in_msg;
    req_len_next    = req_len;
    count_next      = count;
    hdr_idx_next    = hdr_idx;
    len_lo_next     = len_lo;
    res_status_next = res_status;
    res_last_next   = res_last;
    res_use_q_next  = res_use_q;
    mem_req         = '0;

    unique case (state)
      lpmf_pkg::S_IDLE: begin
        if (accept) begin
          res_status_next = lpmf_pkg::ST_OK;
          res_last_next   = 1'b0;
          res_use_q_next  = 1'b0;
          unique case (in_action)
            lpmf_pkg::ACT_START: begin
              req_len_next = in_length;
            end
            lpmf_pkg::ACT_PAYLOAD: begin
              // Store the byte, or drop it when the message is complete
              if (wr_rem == '0) begin
                res_status_next = lpmf_pkg::ST_DROPPED;
              end else begin
                mem_req.en    = 1'b1;
                mem_req.we    = 1'b1;
                mem_req.addr  = wp[lpmf_pkg::ADDR_W-1:0];
                mem_req.wdata = in_data;
                wp_next       = wp + PW'(1);
                wr_rem_next   = wr_rem - LW'(1);
              end
            end
            lpmf_pkg::ACT_READ: begin
              if (in_msg) begin
                // Body byte, unless the writer has not caught up
                if (rp == wp) begin
                  res_status_next = lpmf_pkg::ST_EMPTY;
                end else begin
                  mem_req.en     = 1'b1;
                  mem_req.addr   = rp[lpmf_pkg::ADDR_W-1:0];
                  rp_next        = rp + PW'(1);
                  rd_rem_next    = rd_rem - LW'(1);
                  res_last_next  = (rd_rem == LW'(1));
                  in_msg_next    = (rd_rem != LW'(1));
                  res_use_q_next = 1'b1;
                end
              end else if (used < PW'(lpmf_pkg::HDR_BYTES)) begin
                res_status_next = lpmf_pkg::ST_EMPTY;
              end else begin
                // Fetch header byte 0
                mem_req.en   = 1'b1;
                mem_req.addr = rp[lpmf_pkg::ADDR_W-1:0];
                rp_next      = rp + PW'(1);
              end
            end
            lpmf_pkg::ACT_CLEAR: begin
              wp_next     = '0;
              rp_next     = '0;
              wr_rem_next = '0;
              rd_rem_next = '0;
              in_msg_next = 1'b0;
            end
          endcase
        end
      end
      lpmf_pkg::S_FILL: begin
        // Pad the unfinished message with zero bytes
        mem_req.en   = 1'b1;
        mem_req.we   = 1'b1;
        mem_req.addr = wp[lpmf_pkg::ADDR_W-1:0];
        wp_next      = wp + PW'(1);
        wr_rem_next  = wr_rem - LW'(1);
      end
      lpmf_pkg::S_START: begin
        // Refuse, or cut the length to the room left behind the header
        if (room <= PW'(lpmf_pkg::HDR_BYTES)) begin
          res_status_next = lpmf_pkg::ST_NO_ROOM;
        end else begin
          count_next   = count_new;
          hdr_idx_next = 2'd0;
        end
      end
      lpmf_pkg::S_HDR: begin
        mem_req.en    = 1'b1;
        mem_req.we    = 1'b1;
        mem_req.addr  = wp[lpmf_pkg::ADDR_W-1:0];
        mem_req.wdata = hdr_byte;
        wp_next       = wp + PW'(1);
        hdr_idx_next  = hdr_idx + 2'd1;
        if (hdr_idx == 2'd3) begin
          wr_rem_next     = count;
          res_status_next = (count == '0) ? lpmf_pkg::ST_ZERO_LEN : lpmf_pkg::ST_OK;
        end
      end
      lpmf_pkg::S_RHDR1: begin
        // Take header byte 0, fetch byte 1
        len_lo_next  = mem_rdata;
        mem_req.en   = 1'b1;
        mem_req.addr = rp[lpmf_pkg::ADDR_W-1:0];
        rp_next      = rp + PW'(1);
      end
      lpmf_pkg::S_RHDR2: begin
        // Skip the two upper header bytes and start the body
        rp_next = rp_body;
        if (hdr_len == '0) begin
          res_status_next = lpmf_pkg::ST_ZERO_LEN;
        end else begin
          in_msg_next = 1'b1;
          rd_rem_next = hdr_len;
          if (rp_body == wp) begin
            res_status_next = lpmf_pkg::ST_EMPTY;
          end else begin
            mem_req.en     = 1'b1;
            mem_req.addr   = rp_body[lpmf_pkg::ADDR_W-1:0];
            rp_next        = rp_body + PW'(1);
            rd_rem_next    = hdr_len - LW'(1);
            res_last_next  = (hdr_len == LW'(1));
            in_msg_next    = (hdr_len != LW'(1));
            res_use_q_next = 1'b1;
          end
        end
      end
      lpmf_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Result fields
  assign res_valid     = (state == lpmf_pkg::S_DONE);
  assign res.status    = res_status;
  assign res.read_data = res_use_q ? mem_rdata : '0;
  assign res.last      = res_last;
  assign res.used      = lpmf_pkg::COUNT_W'(used);
  assign res.free      = lpmf_pkg::COUNT_W'(room);

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= lpmf_pkg::S_IDLE;
      wp      <= '0;
      rp      <= '0;
      wr_rem  <= '0;
      rd_rem  <= '0;
      in_msg  <= 1'b0;
      hdr_idx <= '0;
    end else begin
      state   <= state_next;
      wp      <= wp_next;
      rp      <= rp_next;
      wr_rem  <= wr_rem_next;
      rd_rem  <= rd_rem_next;
      in_msg  <= in_msg_next;
      hdr_idx <= hdr_idx_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_len    <= req_len_next;
    count      <= count_next;
    len_lo     <= len_lo_next;
    res_status <= res_status_next;
    res_last   <= res_last_next;
    res_use_q  <= res_use_q_next;
  end

endmodule

`default_nettype wire

// ----- rtl/lpmf_checker.sv -----
// ----------------------------------------------------------------------------
// lpmf_checker
// Port-level checks of the message FIFO results and input pacing.
// ----------------------------------------------------------------------------
`default_nettype none

module lpmf_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_tvalid,
  input wire logic                            s_tready,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [lpmf_pkg::OUT_DATA_W-1:0] m_tdata,
  input wire logic [2:0]                      m_tuser,
  input wire logic                            m_tlast
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  // Used and free always add up to the ring size
  a_sum: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (14'(m_tdata[20:8]) + 14'(m_tdata[33:21])) == 14'(lpmf_pkg::DEPTH))
    else $error("used plus free differs from ring size");

  // Only a successful read carries data or an end mark
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != lpmf_pkg::ST_OK) |-> (m_tdata[7:0] == 8'h00) && !m_tlast)
    else $error("data on a failed item");

  // One item at a time: ready drops after each input transfer
  a_seq: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

endmodule

bind length_prefixed_message_fifo_core lpmf_checker u_lpmf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire
